// File: hdl/xie_pkg.sv
package xie_pkg;

    // Sizes shared by the front, the queue and the back.
    localparam int ADDRESS_WIDTH_DEF = 48;
    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam int MAX_BYTES         = 10;
    localparam int LEN_W             = 4;

    // Request operations.
    typedef enum logic [3:0] {
        OP_ADD_RR = 4'd0,
        OP_ADD_RI = 4'd1,
        OP_ADD_MI = 4'd2,
        OP_STORE  = 4'd3,
        OP_LOAD   = 4'd4,
        OP_XOR_RR = 4'd5,
        OP_NOP    = 4'd6,
        OP_CALLM  = 4'd7,
        OP_CALLR  = 4'd8,
        OP_RET    = 4'd9,
        OP_PUSH   = 4'd10,
        OP_POP    = 4'd11
    } op_t;

    // Operand size codes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    // Prefix, REX and opcode bytes.
    localparam logic [7:0] PFX_OPSIZE     = 8'h66;
    localparam logic [7:0] REX_BASE       = 8'h40;
    localparam logic [7:0] REX_B          = 8'h41;
    localparam logic [7:0] REX_R          = 8'h44;
    localparam logic [7:0] OPC_ADD_RM8    = 8'h00;
    localparam logic [7:0] OPC_ADD_RM     = 8'h01;
    localparam logic [7:0] OPC_XOR_RM8    = 8'h30;
    localparam logic [7:0] OPC_XOR_RM     = 8'h31;
    localparam logic [7:0] OPC_GRP1_8     = 8'h80;
    localparam logic [7:0] OPC_GRP1       = 8'h81;
    localparam logic [7:0] OPC_MOV_ST8    = 8'h88;
    localparam logic [7:0] OPC_MOV_ST     = 8'h89;
    localparam logic [7:0] OPC_MOV_LD8    = 8'h8a;
    localparam logic [7:0] OPC_MOV_LD     = 8'h8b;
    localparam logic [7:0] OPC_NOP        = 8'h90;
    localparam logic [7:0] OPC_RET        = 8'hc3;
    localparam logic [7:0] OPC_PUSH       = 8'h50;
    localparam logic [7:0] OPC_POP        = 8'h58;
    localparam logic [7:0] OPC_GRP5       = 8'hff;
    localparam logic [7:0] MODRM_RR       = 8'hc0;
    localparam logic [7:0] MODRM_RIP      = 8'h05;
    localparam logic [7:0] MODRM_CALL_RIP = 8'h15;
    localparam logic [7:0] MODRM_CALL_REG = 8'hd0;

    // One classified instruction before the displacement is known.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
        logic                      has_disp;
        logic [LEN_W-1:0]          dpos;
    } enc_t;

    // Lay out prefix, REX, opcode, ModRM and immediate bytes. The four
    // displacement bytes are left as zero and filled in by the caller.
    function automatic enc_t encode(
        input logic [3:0]  op,
        input logic [1:0]  sc,
        input logic [3:0]  r1,
        input logic [3:0]  r2,
        input logic [31:0] imm
    );
        enc_t             e;
        logic [LEN_W-1:0] n;
        logic             isbyte;
        logic [2:0]       dsz;
        e      = '0;
        n      = '0;
        isbyte = (sc == SIZE_BYTE);
        dsz    = isbyte ? 3'd1 : (sc == SIZE_WORD) ? 3'd2 : 3'd4;

        // Operand-size prefix for word forms.
        if (sc == SIZE_WORD && (op <= OP_XOR_RR || op == OP_PUSH || op == OP_POP))
        begin
            e.bytes[n] = PFX_OPSIZE;
            n = n + 1'b1;
        end

        unique case (op)
            OP_ADD_RR, OP_XOR_RR:
            begin
                if (r1[3] || r2[3])
                begin
                    e.bytes[n] = REX_BASE | {5'b0, r1[3], 1'b0, r2[3]};
                    n = n + 1'b1;
                end
                else if (isbyte && (r1[2] || r2[2]))
                begin
                    e.bytes[n] = REX_BASE;
                    n = n + 1'b1;
                end
                if (op == OP_ADD_RR)
                    e.bytes[n] = isbyte ? OPC_ADD_RM8 : OPC_ADD_RM;
                else
                    e.bytes[n] = isbyte ? OPC_XOR_RM8 : OPC_XOR_RM;
                n = n + 1'b1;
                e.bytes[n] = MODRM_RR | {2'b00, r1[2:0], r2[2:0]};
                n = n + 1'b1;
            end
            OP_ADD_RI:
            begin
                if (r1[3])
                begin
                    e.bytes[n] = REX_B;
                    n = n + 1'b1;
                end
                else if (isbyte && r1[2])
                begin
                    e.bytes[n] = REX_BASE;
                    n = n + 1'b1;
                end
                e.bytes[n] = isbyte ? OPC_GRP1_8 : OPC_GRP1;
                n = n + 1'b1;
                e.bytes[n] = MODRM_RR | {5'b0, r1[2:0]};
                n = n + 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    if (i < int'(dsz))
                    begin
                        e.bytes[n] = imm[8*i +: 8];
                        n = n + 1'b1;
                    end
                end
            end
            OP_ADD_MI:
            begin
                e.bytes[n] = isbyte ? OPC_GRP1_8 : OPC_GRP1;
                n = n + 1'b1;
                e.bytes[n] = MODRM_RIP;
                n = n + 1'b1;
                e.dpos     = n;
                e.has_disp = 1'b1;
                n = n + LEN_W'(4);
                for (int i = 0; i < 4; i++)
                begin
                    if (i < int'(dsz))
                    begin
                        e.bytes[n] = imm[8*i +: 8];
                        n = n + 1'b1;
                    end
                end
            end
            OP_STORE, OP_LOAD:
            begin
                if (r1[3])
                begin
                    e.bytes[n] = REX_R;
                    n = n + 1'b1;
                end
                else if (isbyte && r1[2])
                begin
                    e.bytes[n] = REX_BASE;
                    n = n + 1'b1;
                end
                if (op == OP_STORE)
                    e.bytes[n] = isbyte ? OPC_MOV_ST8 : OPC_MOV_ST;
                else
                    e.bytes[n] = isbyte ? OPC_MOV_LD8 : OPC_MOV_LD;
                n = n + 1'b1;
                e.bytes[n] = MODRM_RIP | {2'b00, r1[2:0], 3'b000};
                n = n + 1'b1;
                e.dpos     = n;
                e.has_disp = 1'b1;
                n = n + LEN_W'(4);
            end
            OP_NOP:
            begin
                e.bytes[n] = OPC_NOP;
                n = n + 1'b1;
            end
            OP_CALLM:
            begin
                e.bytes[n] = OPC_GRP5;
                n = n + 1'b1;
                e.bytes[n] = MODRM_CALL_RIP;
                n = n + 1'b1;
                e.dpos     = n;
                e.has_disp = 1'b1;
                n = n + LEN_W'(4);
            end
            OP_CALLR:
            begin
                if (r1[3])
                begin
                    e.bytes[n] = REX_B;
                    n = n + 1'b1;
                end
                e.bytes[n] = OPC_GRP5;
                n = n + 1'b1;
                e.bytes[n] = MODRM_CALL_REG | {5'b0, r1[2:0]};
                n = n + 1'b1;
            end
            OP_RET:
            begin
                e.bytes[n] = OPC_RET;
                n = n + 1'b1;
            end
            OP_PUSH, OP_POP:
            begin
                if (r1[3])
                begin
                    e.bytes[n] = REX_B;
                    n = n + 1'b1;
                end
                e.bytes[n] = ((op == OP_PUSH) ? OPC_PUSH : OPC_POP) | {5'b0, r1[2:0]};
                n = n + 1'b1;
            end
            default:
            begin
                // Unused operation codes produce no bytes.
                n = '0;
            end
        endcase

        e.len = n;
        return e;
    endfunction

endpackage

// File: hdl/xie_front.sv
module xie_front #(
    parameter int ADDRESS_WIDTH = xie_pkg::ADDRESS_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [3:0]                         opcode,
    input  logic [1:0]                         size_code,
    input  logic [3:0]                         first_reg,
    input  logic [3:0]                         second_reg,
    input  logic signed [31:0]                 immediate,
    input  logic [ADDRESS_WIDTH-1:0]           target_address,
    input  logic [ADDRESS_WIDTH-1:0]           code_address,
    output logic                               enc_valid,
    input  logic                               enc_ready,
    output logic [xie_pkg::MAX_BYTES-1:0][7:0] enc_bytes,
    output logic [xie_pkg::LEN_W-1:0]          enc_len,
    output logic [ADDRESS_WIDTH-1:0]           enc_next
);
    import xie_pkg::*;

    enc_t                      dec;
    logic [ADDRESS_WIDTH-1:0]  next_addr;
    logic [31:0]               disp;
    logic [MAX_BYTES-1:0][7:0] bytes_mux;
    logic                      accept;
    logic                      valid_reg;
    logic                      valid_next;
    logic [MAX_BYTES-1:0][7:0] bytes_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [ADDRESS_WIDTH-1:0]  next_reg;

    // Classify the request, find the end address and the RIP-relative
    // displacement, and drop the displacement bytes into place.
    always_comb
    begin
        logic [LEN_W-1:0] rel;
        dec       = encode(opcode, size_code, first_reg, second_reg, immediate);
        next_addr = code_address + ADDRESS_WIDTH'(dec.len);
        disp      = target_address[31:0] - next_addr[31:0];
        bytes_mux = dec.bytes;
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            rel = LEN_W'(k) - dec.dpos;
            if (dec.has_disp && LEN_W'(k) >= dec.dpos && rel < LEN_W'(4))
                bytes_mux[k] = 8'(disp >> {rel[1:0], 3'b000});
        end
    end

    // The output register frees up whenever the queue takes its beat.
    assign in_ready = !valid_reg || enc_ready;
    assign accept   = in_valid && in_ready;

    // Requests with an unused operation code are taken but never queued.
    always_comb
    begin
        if (accept)
            valid_next = (dec.len != '0);
        else if (enc_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg <= bytes_mux;
            len_reg   <= dec.len;
            next_reg  <= next_addr;
        end
    end

    assign enc_valid = valid_reg;
    assign enc_bytes = bytes_reg;
    assign enc_len   = len_reg;
    assign enc_next  = next_reg;

    // A held beat keeps its contents until the queue takes it.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !enc_ready |=> valid_reg && $stable(len_reg) && $stable(next_reg))
        else $error("front beat changed while stalled");

    // Only instructions with at least one byte are handed on.
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> len_reg != '0 && len_reg <= LEN_W'(MAX_BYTES))
        else $error("front beat with bad length");

endmodule

// File: hdl/xie_queue.sv
module xie_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = xie_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // The fill count never passes the depth.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue overfilled");

endmodule

// File: hdl/xie_back.sv
module xie_back #(
    parameter int ADDRESS_WIDTH = xie_pkg::ADDRESS_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  logic [xie_pkg::MAX_BYTES-1:0][7:0] q_bytes,
    input  logic [xie_pkg::LEN_W-1:0]          q_len,
    input  logic [ADDRESS_WIDTH-1:0]           q_next,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         code_byte,
    output logic [xie_pkg::LEN_W-1:0]          byte_offset,
    output logic                               last_byte,
    output logic [ADDRESS_WIDTH-1:0]           next_address
);
    import xie_pkg::*;

    logic                      active_reg;
    logic                      active_next;
    logic [LEN_W-1:0]          idx_reg;
    logic [LEN_W-1:0]          idx_next;
    logic [MAX_BYTES-1:0][7:0] bytes_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [ADDRESS_WIDTH-1:0]  next_reg;
    logic                      fire;
    logic                      last;
    logic                      load;

    // Step through the current instruction one byte per beat and pick up
    // the next one from the queue as the last byte leaves.
    always_comb
    begin
        last        = (LEN_W'(idx_reg + 1'b1) == len_reg);
        fire        = active_reg && out_ready;
        q_ready     = !active_reg || (fire && last);
        load        = q_valid && q_ready;
        active_next = active_reg;
        idx_next    = idx_reg;
        if (load)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (fire)
        begin
            active_next = !last;
            idx_next    = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= q_bytes;
            len_reg   <= q_len;
            next_reg  <= q_next;
        end
    end

    assign out_valid    = active_reg;
    assign code_byte    = bytes_reg[idx_reg];
    assign byte_offset  = idx_reg;
    assign last_byte    = last;
    assign next_address = next_reg;

    // The byte index stays inside the current instruction.
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> idx_reg < len_reg)
        else $error("byte index past instruction end");

    // A byte that is not the last one moves the index by exactly one.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last |=> active_reg && idx_reg == $past(idx_reg) + 1'b1)
        else $error("byte index skipped");

endmodule

// File: hdl/x86_64_instruction_encoder.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   opcode, size_code, first_reg, second_reg,
//                                immediate, target_address, code_address
// out      out_valid / out_ready code_byte, byte_offset, last_byte, next_address
//
// An accepted request passes the front register, the queue and the byte
// register before its first byte shows on the output. An instruction of n
// bytes takes n output beats (1 to 10), and the back end picks up the next
// instruction as the last byte leaves, so a steady stream is set by the
// one-byte output port. The front takes a new request every cycle while the
// queue has room. Reset clears all valid flags, pointers and the byte index.
// Requests with an unused operation code are taken and produce no beat.
module x86_64_instruction_encoder #(
    parameter int ADDRESS_WIDTH = xie_pkg::ADDRESS_WIDTH_DEF,
    parameter int QUEUE_DEPTH   = xie_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [3:0]                opcode,
    input  logic [1:0]                size_code,
    input  logic [3:0]                first_reg,
    input  logic [3:0]                second_reg,
    input  logic signed [31:0]        immediate,
    input  logic [ADDRESS_WIDTH-1:0]  target_address,
    input  logic [ADDRESS_WIDTH-1:0]  code_address,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                code_byte,
    output logic [xie_pkg::LEN_W-1:0] byte_offset,
    output logic                      last_byte,
    output logic [ADDRESS_WIDTH-1:0]  next_address
);
    import xie_pkg::*;

    localparam int BYTES_W = MAX_BYTES * 8;
    localparam int Q_W     = BYTES_W + LEN_W + ADDRESS_WIDTH;

    logic                      enc_valid;
    logic                      enc_ready;
    logic [MAX_BYTES-1:0][7:0] enc_bytes;
    logic [LEN_W-1:0]          enc_len;
    logic [ADDRESS_WIDTH-1:0]  enc_next;
    logic                      q_valid;
    logic                      q_ready;
    logic [Q_W-1:0]            q_data;

    // Front end: classify and lay out each instruction.
    xie_front #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .size_code      (size_code),
        .first_reg      (first_reg),
        .second_reg     (second_reg),
        .immediate      (immediate),
        .target_address (target_address),
        .code_address   (code_address),
        .enc_valid      (enc_valid),
        .enc_ready      (enc_ready),
        .enc_bytes      (enc_bytes),
        .enc_len        (enc_len),
        .enc_next       (enc_next)
    );

    // Short queue between the two halves.
    xie_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (enc_valid),
        .push_ready (enc_ready),
        .push_data  ({enc_next, enc_len, enc_bytes}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // Back end: send the bytes out one beat at a time.
    xie_back #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_bytes      (q_data[BYTES_W-1:0]),
        .q_len        (q_data[BYTES_W +: LEN_W]),
        .q_next       (q_data[BYTES_W + LEN_W +: ADDRESS_WIDTH]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_byte    (code_byte),
        .byte_offset  (byte_offset),
        .last_byte    (last_byte),
        .next_address (next_address)
    );

endmodule
